// ----- hw/rtl/cau_pkg.sv -----
// shared types and constants for the complex arithmetic unit
// no dependencies
`default_nettype none
package cau_pkg;

  localparam int W   = 32;            // word width, two's complement
  localparam int F   = 16;            // fraction bits
  localparam int PW  = 2 * W;         // product width
  localparam int NB  = PW + F;        // dividend width, also the number of cells

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4,
    OP_EQ  = 3'd5
  } op_e;

  // one request as it travels down the cell row
  typedef struct packed {
    logic          valid;
    op_e           op;
    logic          neg_re;
    logic          neg_im;
    logic [NB-1:0] n_re;     // dividend bits in, quotient bits out
    logic [NB-1:0] n_im;
    logic [PW-1:0] r_re;     // partial remainder (root remainder for modulus)
    logic [PW-1:0] r_im;
    logic [W-1:0]  root;
    logic [PW-1:0] den;
    logic [W-1:0]  res_re;   // finished result for the short operations
    logic [W-1:0]  res_im;
    logic          eq;
    logic          dz;
    logic          sat;
  } cell_t;

endpackage
`default_nettype wire

// ----- hw/rtl/complex_arithmetic_unit_core.sv -----
// top level of the complex arithmetic unit: front stages, cell row, output stage
// depends on cau_pkg, cau_front, cau_cell, cau_back
//
// channel  direction  handshake               payload
// in       request    in_valid_i / in_stall_o   cmd, a_re, a_im, b_re, b_im
// out      result     out_valid_o / out_stall_i res_re, res_im, is_equal,
//                                               div_by_zero, saturated
//
// one request per cycle while the output is not stalled; every request goes
// through the front stages, the cell row and the output register, the same for
// every operation; the row has 80 cells, one quotient bit per cell for divide
// and one root bit per cell for modulus
// reset clears all valid flags at once, no clearing pass
// a held result on a stalled output freezes the whole pipe; in_stall_o follows
`default_nettype none
module complex_arithmetic_unit_core import cau_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          cmd_i,
  input  logic signed [W-1:0] a_re_i,
  input  logic signed [W-1:0] a_im_i,
  input  logic signed [W-1:0] b_re_i,
  input  logic signed [W-1:0] b_im_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [W-1:0] res_re_o,
  output logic signed [W-1:0] res_im_o,
  output logic                is_equal_o,
  output logic                div_by_zero_o,
  output logic                saturated_o
);

  // the pipe moves unless a finished result is being held
  logic  en;
  cell_t chain [NB+1];

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // operand registers, products, setup of divide and root
  cau_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .a_re_i     (a_re_i),
    .a_im_i     (a_im_i),
    .b_re_i     (b_re_i),
    .b_im_i     (b_im_i),
    .cell_o     (chain[0])
  );

  // row of cells, each a registered divide or root step
  for (genvar i = 0; i < NB; i++) begin : g_cell
    cau_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  // sign, clipping, output register
  cau_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .cell_i   (chain[NB]),
    .valid_o  (out_valid_o),
    .res_re_o (res_re_o),
    .res_im_o (res_im_o),
    .eq_o     (is_equal_o),
    .dz_o     (div_by_zero_o),
    .sat_o    (saturated_o)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/cau_front.sv -----
// operand registers, products and setup of a request for the cell row
// depends on cau_pkg
`default_nettype none
module cau_front import cau_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                in_valid_i,
  input  logic [2:0]          cmd_i,
  input  logic signed [W-1:0] a_re_i,
  input  logic signed [W-1:0] a_im_i,
  input  logic signed [W-1:0] b_re_i,
  input  logic signed [W-1:0] b_im_i,
  output cell_t               cell_o
);

  // clip a wide signed value to the word, flag in the top bit
  function automatic logic [W:0] sat_w(input logic signed [PW:0] v);
    logic hi;
    logic lo;
    hi = !v[PW] && (|v[PW-1:W-1]);
    lo = v[PW] && !(&v[PW-1:W-1]);
    if (hi) sat_w = {1'b1, 1'b0, {(W-1){1'b1}}};
    else if (lo) sat_w = {1'b1, 1'b1, {(W-1){1'b0}}};
    else sat_w = {1'b0, v[W-1:0]};
  endfunction

  function automatic logic [W-1:0] mag(input logic [W-1:0] x);
    mag = x[W-1] ? (~x + {{(W-1){1'b0}}, 1'b1}) : x;
  endfunction

  // stage 0: operand registers
  logic                s0_v_q;
  op_e                 s0_op_q;
  logic signed [W-1:0] s0_ar_q, s0_ai_q, s0_br_q, s0_bi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (en_i) begin
      s0_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_op_q <= op_e'(cmd_i);
      s0_ar_q <= a_re_i;
      s0_ai_q <= a_im_i;
      s0_br_q <= b_re_i;
      s0_bi_q <= b_im_i;
    end
  end

  // stage 1: products and the short operations
  logic signed [PW-1:0] p_rr_d, p_ii_d, p_ri_d, p_ir_d;
  logic [PW-1:0]        sq0_d, sq1_d;
  logic [W-1:0]         m0, m1;
  logic signed [W:0]    s_re, s_im;
  logic [W:0]           c_re, c_im;
  logic [W-1:0]         re1_d, im1_d;
  logic                 eq1_d, dz1_d, sat1_d;

  assign p_rr_d = s0_ar_q * s0_br_q;
  assign p_ii_d = s0_ai_q * s0_bi_q;
  assign p_ri_d = s0_ar_q * s0_bi_q;
  assign p_ir_d = s0_ai_q * s0_br_q;
  assign m0     = (s0_op_q == OP_MOD) ? mag(s0_ar_q) : mag(s0_br_q);
  assign m1     = (s0_op_q == OP_MOD) ? mag(s0_ai_q) : mag(s0_bi_q);
  assign sq0_d  = PW'(m0) * PW'(m0);
  assign sq1_d  = PW'(m1) * PW'(m1);

  always_comb begin
    re1_d  = '0;
    im1_d  = '0;
    eq1_d  = 1'b0;
    dz1_d  = 1'b0;
    sat1_d = 1'b0;
    s_re   = '0;
    s_im   = '0;
    c_re   = '0;
    c_im   = '0;
    unique case (s0_op_q)
      OP_ADD, OP_SUB: begin
        if (s0_op_q == OP_ADD) begin
          s_re = (W+1)'(s0_ar_q) + (W+1)'(s0_br_q);
          s_im = (W+1)'(s0_ai_q) + (W+1)'(s0_bi_q);
        end else begin
          s_re = (W+1)'(s0_ar_q) - (W+1)'(s0_br_q);
          s_im = (W+1)'(s0_ai_q) - (W+1)'(s0_bi_q);
        end
        c_re   = sat_w((PW+1)'(s_re));
        c_im   = sat_w((PW+1)'(s_im));
        re1_d  = c_re[W-1:0];
        im1_d  = c_im[W-1:0];
        sat1_d = c_re[W] | c_im[W];
      end
      OP_DIV:  dz1_d = (s0_br_q == '0) && (s0_bi_q == '0);
      OP_EQ:   eq1_d = (s0_ar_q == s0_br_q) && (s0_ai_q == s0_bi_q);
      default: ;
    endcase
  end

  logic                 s1_v_q;
  op_e                  s1_op_q;
  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic [PW-1:0]        sq0_q, sq1_q;
  logic [W-1:0]         re1_q, im1_q;
  logic                 eq1_q, dz1_q, sat1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en_i) begin
      s1_v_q <= s0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_op_q <= s0_op_q;
      p_rr_q  <= p_rr_d;
      p_ii_q  <= p_ii_d;
      p_ri_q  <= p_ri_d;
      p_ir_q  <= p_ir_d;
      sq0_q   <= sq0_d;
      sq1_q   <= sq1_d;
      re1_q   <= re1_d;
      im1_q   <= im1_d;
      eq1_q   <= eq1_d;
      dz1_q   <= dz1_d;
      sat1_q  <= sat1_d;
    end
  end

  // stage 2: multiply results, dividend and divisor, radicand
  logic signed [PW:0] mre, mim, nre, nim;
  logic [W:0]         cm_re, cm_im;
  logic [PW:0]        ure, uim;
  logic [PW-1:0]      sum_sq;
  cell_t              c_d, c_q;

  assign mre    = ((PW+1)'(p_rr_q) - (PW+1)'(p_ii_q)) >>> F;
  assign mim    = ((PW+1)'(p_ri_q) + (PW+1)'(p_ir_q)) >>> F;
  assign nre    = (PW+1)'(p_rr_q) + (PW+1)'(p_ii_q);
  assign nim    = (PW+1)'(p_ir_q) - (PW+1)'(p_ri_q);
  assign ure    = nre[PW] ? -nre : nre;
  assign uim    = nim[PW] ? -nim : nim;
  assign cm_re  = sat_w(mre);
  assign cm_im  = sat_w(mim);
  assign sum_sq = sq0_q + sq1_q;

  always_comb begin
    c_d        = '0;
    c_d.valid  = s1_v_q;
    c_d.op     = s1_op_q;
    c_d.res_re = re1_q;
    c_d.res_im = im1_q;
    c_d.eq     = eq1_q;
    c_d.dz     = dz1_q;
    c_d.sat    = sat1_q;
    unique case (s1_op_q)
      OP_MUL: begin
        c_d.res_re = cm_re[W-1:0];
        c_d.res_im = cm_im[W-1:0];
        c_d.sat    = cm_re[W] | cm_im[W];
      end
      OP_DIV: begin
        c_d.neg_re = nre[PW];
        c_d.neg_im = nim[PW];
        c_d.n_re   = {ure[PW-1:0], {F{1'b0}}};
        c_d.n_im   = {uim[PW-1:0], {F{1'b0}}};
        c_d.den    = sum_sq;
      end
      // radicand sits at the low end of the joined dividend registers
      OP_MOD:  c_d.n_im = NB'(sum_sq);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0;
    end else if (en_i) begin
      c_q <= c_d;
    end
  end

  assign cell_o = c_q;

endmodule
`default_nettype wire

// ----- hw/rtl/cau_cell.sv -----
// one cell of the row: a restoring divide step on both parts, or a root step
// depends on cau_pkg
`default_nettype none
module cau_cell import cau_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  cell_t cell_i,
  output cell_t cell_o
);

  logic [PW:0]  t_re, t_im, d_re, d_im, dv;
  logic         ge_re, ge_im, ge_rt;
  logic [W+3:0] ts, trial, sd;
  cell_t        nxt, c_q;

  assign dv    = {1'b0, cell_i.den};
  assign t_re  = {cell_i.r_re, cell_i.n_re[NB-1]};
  assign t_im  = {cell_i.r_im, cell_i.n_im[NB-1]};
  assign ge_re = t_re >= dv;
  assign ge_im = t_im >= dv;
  assign d_re  = t_re - dv;
  assign d_im  = t_im - dv;

  // root remainder stays below twice the root plus one
  assign ts    = {cell_i.r_re[W+1:0], cell_i.n_re[NB-1:NB-2]};
  assign trial = {2'b00, cell_i.root, 2'b01};
  assign ge_rt = ts >= trial;
  assign sd    = ts - trial;

  always_comb begin
    nxt = cell_i;
    unique case (cell_i.op)
      OP_DIV: begin
        nxt.r_re = ge_re ? d_re[PW-1:0] : t_re[PW-1:0];
        nxt.r_im = ge_im ? d_im[PW-1:0] : t_im[PW-1:0];
        nxt.n_re = {cell_i.n_re[NB-2:0], ge_re};
        nxt.n_im = {cell_i.n_im[NB-2:0], ge_im};
      end
      OP_MOD: begin
        nxt.r_re = PW'(ge_rt ? sd[W+1:0] : ts[W+1:0]);
        nxt.n_re = {cell_i.n_re[NB-3:0], cell_i.n_im[NB-1:NB-2]};
        nxt.n_im = {cell_i.n_im[NB-3:0], 2'b00};
        nxt.root = {cell_i.root[W-2:0], ge_rt};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0;
    end else if (en_i) begin
      c_q <= nxt;
    end
  end

  assign cell_o = c_q;

endmodule
`default_nettype wire

// ----- hw/rtl/cau_back.sv -----
// sign, clipping and output register at the end of the cell row
// depends on cau_pkg
`default_nettype none
module cau_back import cau_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  cell_t        cell_i,
  output logic         valid_o,
  output logic [W-1:0] res_re_o,
  output logic [W-1:0] res_im_o,
  output logic         eq_o,
  output logic         dz_o,
  output logic         sat_o
);

  function automatic logic [W:0] qsat(input logic [NB-1:0] q, input logic neg);
    logic clip;
    if (!neg) begin
      clip = |q[NB-1:W-1];
      qsat = clip ? {1'b1, 1'b0, {(W-1){1'b1}}} : {1'b0, q[W-1:0]};
    end else begin
      clip = (|q[NB-1:W]) || (q[W-1] && (|q[W-2:0]));
      qsat = clip ? {1'b1, 1'b1, {(W-1){1'b0}}} : {1'b0, -q[W-1:0]};
    end
  endfunction

  logic [W:0]   q_re, q_im;
  logic [W-1:0] re_d, im_d;
  logic         sat_d;
  logic         v_q;
  logic [W-1:0] re_q, im_q;
  logic         eq_q, dz_q, sat_q;

  assign q_re = qsat(cell_i.n_re, cell_i.neg_re);
  assign q_im = qsat(cell_i.n_im, cell_i.neg_im);

  always_comb begin
    re_d  = cell_i.res_re;
    im_d  = cell_i.res_im;
    sat_d = cell_i.sat;
    if (cell_i.op == OP_DIV && !cell_i.dz) begin
      re_d  = q_re[W-1:0];
      im_d  = q_im[W-1:0];
      sat_d = q_re[W] | q_im[W];
    end else if (cell_i.op == OP_MOD) begin
      re_d  = cell_i.root[W-1] ? {1'b0, {(W-1){1'b1}}} : cell_i.root;
      im_d  = '0;
      sat_d = cell_i.root[W-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      re_q  <= re_d;
      im_q  <= im_d;
      eq_q  <= cell_i.eq;
      dz_q  <= cell_i.dz;
      sat_q <= sat_d;
    end
  end

  assign valid_o  = v_q;
  assign res_re_o = re_q;
  assign res_im_o = im_q;
  assign eq_o     = eq_q;
  assign dz_o     = dz_q;
  assign sat_o    = sat_q;

endmodule
`default_nettype wire
